// File: rtl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared codes, types and fixed sizes of the polyphonic voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

  localparam int NUM_KEYS = 128;
  localparam int KEY_W    = 7;
  localparam int DEPTH_W  = 8;
  localparam int MASK_W   = 16;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;
  localparam logic [4:0]         LIM_MAX   = 5'd16;

  localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
  localparam logic [2:0] CMD_BLOCK    = 3'd2;
  localparam logic [2:0] CMD_FINISHED = 3'd3;
  localparam logic [2:0] CMD_ALL_OFF  = 3'd4;

  localparam logic [2:0] KIND_IGNORED = 3'd0;
  localparam logic [2:0] KIND_START   = 3'd1;
  localparam logic [2:0] KIND_LEGATO  = 3'd2;
  localparam logic [2:0] KIND_RELEASE = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  localparam logic [4:0] CHAN_BASE = 5'd0;
  localparam logic [4:0] CHAN_ALT  = 5'd1;
  localparam logic [4:0] CHAN_OMNI = 5'd16;

  localparam logic [3:0] REG_POLY_LIMIT = 4'd0;
  localparam logic [3:0] REG_LEGATO     = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic assign_en;
    logic age_en;
    logic free_en;
    logic clear_en;
  } voice_op_t;

endpackage

// File: rtl/pva_ram.sv
// ----------------------------------------------------------------------------
// pva_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pva_voice_bank.sv
// ----------------------------------------------------------------------------
// pva_voice_bank
// Per-voice lanes: active flag, pitch and saturating age, with the parallel
// match, free-voice and release-mask lookups.
// ----------------------------------------------------------------------------
module pva_voice_bank #(
  parameter int NUM_VOICES = 16,
  parameter int AGE_BITS   = 32,
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [4:0]                lim,
  input  logic [pva_pkg::KEY_W-1:0] note,
  input  pva_pkg::voice_op_t        op,
  input  logic [VW-1:0]             op_idx,
  input  logic [15:0]               blk,
  input  logic [VW-1:0]             scan_idx,
  output logic                      match_hit,
  output logic [VW-1:0]             match_idx,
  output logic                      free_hit,
  output logic [VW-1:0]             free_idx,
  output logic                      on_at_idx,
  output logic                      on0,
  output logic [pva_pkg::MASK_W-1:0] release_mask,
  output logic [AGE_BITS-1:0]       scan_age
);

  localparam int MW = (NUM_VOICES < pva_pkg::MASK_W) ? NUM_VOICES : pva_pkg::MASK_W;

  logic [NUM_VOICES-1:0]     on;
  logic [pva_pkg::KEY_W-1:0] pitch   [NUM_VOICES];
  logic [AGE_BITS-1:0]       age     [NUM_VOICES];
  logic [AGE_BITS-1:0]       age_inc [NUM_VOICES];

  // saturating age add per lane
  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_lane
    logic [AGE_BITS:0] sum;
    assign sum = {1'b0, age[g]} + (AGE_BITS + 1)'(blk);
    assign age_inc[g] = sum[AGE_BITS] ? {AGE_BITS{1'b1}} : sum[AGE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on <= '0;
    end else if (op.clear_en) begin
      on <= '0;
    end else if (op.free_en) begin
      on[op_idx] <= 1'b0;
    end else if (op.assign_en) begin
      on[op_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      if (op.age_en && on[i]) begin
        age[i] <= age_inc[i];
      end
      if (op.assign_en && op_idx == VW'(i)) begin
        age[i]   <= '0;
        pitch[i] <= note;
      end
    end
  end

  // lowest usable index wins
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    free_hit  = 1'b0;
    free_idx  = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (i < int'(lim)) begin
        if (on[i] && pitch[i] == note) begin
          match_hit = 1'b1;
          match_idx = VW'(i);
        end
        if (!on[i]) begin
          free_hit = 1'b1;
          free_idx = VW'(i);
        end
      end
    end
  end

  always_comb begin
    release_mask = '0;
    for (int i = 0; i < MW; i++) begin
      release_mask[i] = on[i] && (pitch[i] == note);
    end
  end

  assign on_at_idx = on[op_idx];
  assign on0       = on[0];
  assign scan_age  = age[scan_idx];

endmodule

// File: rtl/poly_voice_allocator.sv
// ----------------------------------------------------------------------------
// poly_voice_allocator
// Voice allocator: key depth read-modify-write in RAM, voice lanes, and an
// oldest-voice scan for stealing.
// ----------------------------------------------------------------------------
// Sequence: the accepting edge registers the event and starts the key depth RAM
//   read; ST_EXEC writes the depth back and registers the result and done. A note
//   on that has to steal gets its result from the oldest-age scan (ST_SCAN) over
//   the usable voices instead. A new event is taken only once the last is through.
// Reset: synchronous; all voices off, all key depths zero through valid bits,
//   poly_limit 16, legato off. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module poly_voice_allocator #(
  parameter int NUM_VOICES = 16,
  parameter int AGE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [4:0]  channel,
  input  logic [6:0]  note,
  input  logic [6:0]  velocity,
  input  logic [15:0] block_samples,
  input  logic [3:0]  finished_voice,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [2:0]  kind,
  output logic [3:0]  voice_index,
  output logic [6:0]  voice_note,
  output logic [6:0]  voice_velocity,
  output logic        was_active,
  output logic [15:0] release_mask,
  output logic [7:0]  held_keys
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  pva_pkg::state_t state, state_next;

  logic [2:0]  cmd_q;
  logic        chan_ok_q;
  logic [6:0]  note_q;
  logic [6:0]  vel_q;
  logic [15:0] blk_q;
  logic [3:0]  fin_q;
  logic        vld_q;

  logic [4:0] poly_limit;
  logic       legato_mode;
  logic [4:0] lim;

  logic [pva_pkg::DEPTH_W-1:0]  held_count, held_next;
  logic [pva_pkg::NUM_KEYS-1:0] key_vld;
  logic                         vld_set, vld_clr;

  logic                         accept;
  logic                         ram_we;
  logic [pva_pkg::DEPTH_W-1:0]  ram_wdata, ram_rdata, depth;

  pva_pkg::voice_op_t op;
  logic [VW-1:0]      op_idx, pick_idx, fin_idx, sel_idx;
  logic               match_hit, free_hit, on_at_idx, on0;
  logic [VW-1:0]      match_idx, free_idx;
  logic [15:0]        mask_w;

  logic [VW-1:0]       scan_idx, best_idx;
  logic [AGE_BITS-1:0] oldest, scan_age;
  logic                scan_take, scan_last, scan_start;

  logic is_on, is_off, legato_hit, steal, fin_ok;

  logic        res_load;
  logic [2:0]  res_kind;
  logic [3:0]  res_idx;
  logic [6:0]  res_note, res_vel;
  logic        res_act;
  logic [15:0] res_mask;

  assign accept    = start && !busy;
  assign busy      = (state != pva_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign held_keys = held_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_limit  <= pva_pkg::LIM_MAX;
      legato_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pva_pkg::REG_POLY_LIMIT: poly_limit  <= cfg_data[4:0];
        pva_pkg::REG_LEGATO:     legato_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lim = poly_limit;
    if (lim == 5'd0) lim = 5'd1;
    if (lim > pva_pkg::LIM_MAX) lim = pva_pkg::LIM_MAX;
    if (int'(lim) > NUM_VOICES) lim = 5'(NUM_VOICES);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= cmd;
      chan_ok_q <= channel inside {pva_pkg::CHAN_BASE, pva_pkg::CHAN_ALT, pva_pkg::CHAN_OMNI};
      note_q    <= note;
      vel_q     <= velocity;
      blk_q     <= block_samples;
      fin_q     <= finished_voice;
      vld_q     <= key_vld[note];
    end
  end

  pva_ram #(
    .WIDTH (pva_pkg::DEPTH_W),
    .DEPTH (pva_pkg::NUM_KEYS)
  ) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (note_q),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (note),
    .rdata (ram_rdata)
  );

  pva_voice_bank #(
    .NUM_VOICES (NUM_VOICES),
    .AGE_BITS   (AGE_BITS)
  ) u_bank (
    .clk          (clk),
    .rst          (rst),
    .lim          (lim),
    .note         (note_q),
    .op           (op),
    .op_idx       (op_idx),
    .blk          (blk_q),
    .scan_idx     (scan_idx),
    .match_hit    (match_hit),
    .match_idx    (match_idx),
    .free_hit     (free_hit),
    .free_idx     (free_idx),
    .on_at_idx    (on_at_idx),
    .on0          (on0),
    .release_mask (mask_w),
    .scan_age     (scan_age)
  );

  assign depth      = vld_q ? ram_rdata : '0;
  assign is_on      = (cmd_q == pva_pkg::CMD_NOTE_ON) && (vel_q != 7'd0) && chan_ok_q;
  assign is_off     = ((cmd_q == pva_pkg::CMD_NOTE_ON) || (cmd_q == pva_pkg::CMD_NOTE_OFF))
                      && chan_ok_q && !is_on;
  assign legato_hit = legato_mode && (held_count != '0) && on0;
  assign steal      = !legato_hit && !match_hit && !free_hit;
  assign fin_ok     = int'(fin_q) < NUM_VOICES;
  assign fin_idx    = VW'(fin_q);

  assign scan_take  = (scan_idx == '0) || (scan_age >= oldest);
  assign scan_last  = (int'(scan_idx) + 1) == int'(lim);
  assign sel_idx    = scan_take ? scan_idx : best_idx;

  always_comb begin
    if (legato_hit)     pick_idx = '0;
    else if (match_hit) pick_idx = match_idx;
    else                pick_idx = free_idx;
  end

  always_comb begin
    if (state == pva_pkg::ST_SCAN)              op_idx = sel_idx;
    else if (cmd_q == pva_pkg::CMD_FINISHED)    op_idx = fin_idx;
    else                                        op_idx = pick_idx;
  end

  always_comb begin
    state_next = state;
    case (state)
      pva_pkg::ST_IDLE: if (accept) state_next = pva_pkg::ST_EXEC;
      pva_pkg::ST_EXEC: state_next = (is_on && steal) ? pva_pkg::ST_SCAN : pva_pkg::ST_IDLE;
      pva_pkg::ST_SCAN: if (scan_last) state_next = pva_pkg::ST_IDLE;
      default:          state_next = pva_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op         = '0;
    ram_we     = 1'b0;
    ram_wdata  = depth;
    held_next  = held_count;
    vld_set    = 1'b0;
    vld_clr    = 1'b0;
    scan_start = 1'b0;
    res_load   = 1'b0;
    res_kind   = pva_pkg::KIND_IGNORED;
    res_idx    = '0;
    res_note   = '0;
    res_vel    = '0;
    res_act    = 1'b0;
    res_mask   = '0;
    case (state)
      pva_pkg::ST_EXEC: begin
        if (is_on) begin
          ram_we    = 1'b1;
          vld_set   = 1'b1;
          ram_wdata = (depth == pva_pkg::DEPTH_MAX) ? depth : depth + 8'd1;
          if (depth == '0) held_next = held_count + 8'd1;
          if (steal) begin
            scan_start = 1'b1;
          end else begin
            op.assign_en = 1'b1;
            res_load     = 1'b1;
            res_kind     = legato_hit ? pva_pkg::KIND_LEGATO : pva_pkg::KIND_START;
            res_idx      = 4'(pick_idx);
            res_note     = note_q;
            res_vel      = vel_q;
            res_act      = on_at_idx;
          end
        end else if (is_off) begin
          if (depth != '0) begin
            ram_we    = 1'b1;
            vld_set   = 1'b1;
            ram_wdata = depth - 8'd1;
            if (depth == 8'd1 && held_count != '0) held_next = held_count - 8'd1;
          end
          res_load = 1'b1;
          res_kind = pva_pkg::KIND_RELEASE;
          res_mask = mask_w;
        end else begin
          res_load = 1'b1;
          case (cmd_q)
            pva_pkg::CMD_BLOCK: begin
              op.age_en = 1'b1;
              res_kind  = pva_pkg::KIND_DONE;
            end
            pva_pkg::CMD_FINISHED: begin
              if (fin_ok) begin
                op.free_en = 1'b1;
                res_kind   = pva_pkg::KIND_DONE;
              end
            end
            pva_pkg::CMD_ALL_OFF: begin
              op.clear_en = 1'b1;
              vld_clr     = 1'b1;
              held_next   = '0;
              res_kind    = pva_pkg::KIND_DONE;
            end
            default: ;
          endcase
        end
      end
      pva_pkg::ST_SCAN: begin
        if (scan_last) begin
          op.assign_en = 1'b1;
          res_load     = 1'b1;
          res_kind     = pva_pkg::KIND_START;
          res_idx      = 4'(sel_idx);
          res_note     = note_q;
          res_vel      = vel_q;
          res_act      = on_at_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pva_pkg::ST_IDLE;
      held_count <= '0;
      key_vld    <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      held_count <= held_next;
      done       <= res_load;
      if (vld_clr) begin
        key_vld <= '0;
      end else if (vld_set) begin
        key_vld[note_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_idx <= '0;
    end else if (state == pva_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
      best_idx <= sel_idx;
      if (scan_take) oldest <= scan_age;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      kind           <= res_kind;
      voice_index    <= res_idx;
      voice_note     <= res_note;
      voice_velocity <= res_vel;
      was_active     <= res_act;
      release_mask   <= res_mask;
    end
  end

endmodule

// File: rtl/pva_checker.sv
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks on the voice allocator: busy, strobe and result codes.
// ----------------------------------------------------------------------------
module pva_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  kind,
  input logic [3:0]  voice_index,
  input logic        was_active,
  input logic [15:0] release_mask
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe outside the end of an event");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (kind == pva_pkg::KIND_IGNORED || kind == pva_pkg::KIND_START ||
              kind == pva_pkg::KIND_LEGATO || kind == pva_pkg::KIND_RELEASE ||
              kind == pva_pkg::KIND_DONE))
    else $error("result kind out of range");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (kind == pva_pkg::KIND_IGNORED || kind == pva_pkg::KIND_DONE))
      |-> (release_mask == 16'd0 && voice_index == 4'd0 && !was_active))
    else $error("nonzero voice fields on a plain result");

  a_legato_active: assert property (@(posedge clk) disable iff (rst)
    (done && kind == pva_pkg::KIND_LEGATO) |-> (was_active && voice_index == 4'd0))
    else $error("legato retarget not on sounding voice 0");

endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .kind         (kind),
  .voice_index  (voice_index),
  .was_active   (was_active),
  .release_mask (release_mask)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polyphonic voice allocator. A short table of
// events exercises the field extremes, every command, foreign channels and
// unknown commands. It is followed by random note traffic at several voice
// limits and both legato settings. The run ends with a key depth saturation
// pass and a pass that steals from voices tied at the oldest age. Each result
// is checked against a typed row outcome or an in-bench voice bank model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int NV = 16;
  localparam logic [31:0] AGE_MAX = '1;
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam logic [4:0] CHAN_STRAY_A = 5'd15;
  localparam logic [4:0] CHAN_STRAY_B = 5'd31;
  localparam logic [3:0] REG_SPARE    = 4'hF;
  localparam int RAND_PER_PHASE = 110;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [15:0] block_samples;
    logic [3:0]  finished_voice;
  } event_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  voice_index;
    logic [6:0]  voice_note;
    logic [6:0]  voice_velocity;
    logic        was_active;
    logic [15:0] release_mask;
    logic [7:0]  held_keys;
  } outcome_t;

  typedef struct packed {
    event_t   ev;
    logic     typed;
    outcome_t want;
  } row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  cmd;
  logic [4:0]  channel;
  logic [6:0]  note;
  logic [6:0]  velocity;
  logic [15:0] block_samples;
  logic [3:0]  finished_voice;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        done;
  logic [2:0]  kind;
  logic [3:0]  voice_index;
  logic [6:0]  voice_note;
  logic [6:0]  voice_velocity;
  logic        was_active;
  logic [15:0] release_mask;
  logic [7:0]  held_keys;

  poly_voice_allocator i_dut (.*);

  // voice bank model
  logic [4:0]  limit_m;
  logic        legato_m;
  logic        on_m[NV];
  logic [6:0]  pitch_m[NV];
  logic [6:0]  vel_m[NV];
  logic [31:0] age_m[NV];
  logic [7:0]  depth_m[128];
  logic [7:0]  held_m;

  outcome_t pending_outcomes[$];
  row_t     script[$];
  logic     row_typed;
  outcome_t row_want;
  outcome_t seen;
  outcome_t wanted;
  outcome_t modeled;
  int       idle_pct;
  int       mismatches;
  int       events_total;
  int       ignored_total;
  int       checks_done;
  int       steals;
  int       retargets;
  int       releases;
  int       cfg_writes;

  int       phase_lim[6]  = '{16, 1, 4, 0, 31, 8};
  bit       phase_leg[6]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  int       phase_idle[6] = '{30, 30, 46, 46, 0, 0};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic bit chan_ok(logic [4:0] ch);
    return ch == pva_pkg::CHAN_BASE || ch == pva_pkg::CHAN_ALT || ch == pva_pkg::CHAN_OMNI;
  endfunction

  function automatic logic [4:0] pick_channel();
    case ($urandom_range(2))
      0: return pva_pkg::CHAN_BASE;
      1: return pva_pkg::CHAN_ALT;
      default: return pva_pkg::CHAN_OMNI;
    endcase
  endfunction

  function automatic event_t ev_of(logic [2:0] c, logic [4:0] ch, logic [6:0] n,
                                   logic [6:0] v, logic [15:0] b, logic [3:0] f);
    event_t e;
    e = '{cmd: c, channel: ch, note: n, velocity: v, block_samples: b,
          finished_voice: f};
    return e;
  endfunction

  function automatic outcome_t out_of(logic [2:0] k, logic [3:0] idx, logic [6:0] n,
                                      logic [6:0] v, logic w, logic [15:0] m,
                                      logic [7:0] h);
    outcome_t o;
    o = '{kind: k, voice_index: idx, voice_note: n, voice_velocity: v,
          was_active: w, release_mask: m, held_keys: h};
    return o;
  endfunction

  function automatic string show(outcome_t o);
    return $sformatf("kind %0d voice %0d note %0d vel %0d active %0d mask %h held %0d",
                     o.kind, o.voice_index, o.voice_note, o.voice_velocity,
                     o.was_active, o.release_mask, o.held_keys);
  endfunction

  function automatic bit is_noise(event_t e);
    return e.cmd > pva_pkg::CMD_ALL_OFF ||
           ((e.cmd == pva_pkg::CMD_NOTE_ON || e.cmd == pva_pkg::CMD_NOTE_OFF) &&
            !chan_ok(e.channel));
  endfunction

  function automatic outcome_t allocate_voice(event_t e);
    outcome_t    o;
    logic [7:0]  held_before;
    logic [31:0] room;
    logic [31:0] oldest;
    int          lim;
    int          pick;
    o = '0;
    if (e.cmd == pva_pkg::CMD_NOTE_ON && e.velocity != 0 && chan_ok(e.channel)) begin
      held_before = held_m;
      if (depth_m[e.note] == 0) held_m++;
      if (depth_m[e.note] != pva_pkg::DEPTH_MAX) depth_m[e.note]++;
      if (legato_m && held_before != 0 && on_m[0]) begin
        pick = 0;
        o.was_active = 1'b1;
        o.kind = pva_pkg::KIND_LEGATO;
      end else begin
        lim = (limit_m == 0) ? 1 :
              (limit_m > pva_pkg::LIM_MAX) ? int'(pva_pkg::LIM_MAX) : int'(limit_m);
        if (lim > NV) lim = NV;
        pick = -1;
        for (int i = 0; i < lim; i++)
          if (pick < 0 && on_m[i] && pitch_m[i] == e.note) pick = i;
        for (int i = 0; i < lim; i++)
          if (pick < 0 && !on_m[i]) pick = i;
        if (pick < 0) begin
          oldest = '0;
          pick = 0;
          for (int i = 0; i < lim; i++)
            if (age_m[i] >= oldest) begin
              oldest = age_m[i];
              pick = i;
            end
        end
        o.was_active = on_m[pick];
        o.kind = pva_pkg::KIND_START;
      end
      on_m[pick] = 1'b1;
      pitch_m[pick] = e.note;
      vel_m[pick] = e.velocity;
      age_m[pick] = '0;
      o.voice_index = 4'(pick);
      o.voice_note = e.note;
      o.voice_velocity = e.velocity;
    end else if ((e.cmd == pva_pkg::CMD_NOTE_ON || e.cmd == pva_pkg::CMD_NOTE_OFF) &&
                 chan_ok(e.channel)) begin
      if (depth_m[e.note] != 0) begin
        depth_m[e.note]--;
        if (depth_m[e.note] == 0 && held_m != 0) held_m--;
      end
      for (int i = 0; i < NV && i < pva_pkg::MASK_W; i++)
        if (on_m[i] && pitch_m[i] == e.note) o.release_mask[i] = 1'b1;
      o.kind = pva_pkg::KIND_RELEASE;
    end else if (e.cmd == pva_pkg::CMD_BLOCK) begin
      for (int i = 0; i < NV; i++)
        if (on_m[i]) begin
          room = AGE_MAX - age_m[i];
          age_m[i] = (32'(e.block_samples) > room) ? AGE_MAX : age_m[i] + e.block_samples;
        end
      o.kind = pva_pkg::KIND_DONE;
    end else if (e.cmd == pva_pkg::CMD_FINISHED) begin
      if (int'(e.finished_voice) < NV) begin
        on_m[e.finished_voice] = 1'b0;
        o.kind = pva_pkg::KIND_DONE;
      end
    end else if (e.cmd == pva_pkg::CMD_ALL_OFF) begin
      for (int i = 0; i < 128; i++) depth_m[i] = '0;
      for (int i = 0; i < NV; i++) on_m[i] = 1'b0;
      held_m = '0;
      o.kind = pva_pkg::KIND_DONE;
    end
    o.held_keys = held_m;
    return o;
  endfunction

  function automatic event_t random_event();
    event_t e;
    int     r;
    e = ev_of(3'($urandom), 5'($urandom), 7'($urandom), 7'($urandom), 16'($urandom),
              4'($urandom));
    r = $urandom_range(99);
    if (r < 90) begin
      e.channel = pick_channel();
      e.note = ($urandom_range(3) != 0) ? 7'(48 + $urandom_range(11)) : 7'($urandom);
    end
    if (r < 36) begin
      e.cmd = pva_pkg::CMD_NOTE_ON;
      e.velocity = ($urandom_range(15) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
    end else if (r < 60) begin
      e.cmd = pva_pkg::CMD_NOTE_OFF;
    end else if (r < 75) begin
      e.cmd = pva_pkg::CMD_BLOCK;
      if ($urandom_range(3) != 0) e.block_samples = 16'($urandom_range(2000));
    end else if (r < 87) begin
      e.cmd = pva_pkg::CMD_FINISHED;
    end else if (r < 90) begin
      e.cmd = pva_pkg::CMD_ALL_OFF;
    end else if ($urandom_range(1) == 0) begin
      e.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end else begin
      e.cmd = $urandom_range(1) ? pva_pkg::CMD_NOTE_OFF : pva_pkg::CMD_NOTE_ON;
      while (chan_ok(e.channel)) e.channel = 5'($urandom);
    end
    return e;
  endfunction

  task automatic add_row(event_t e, logic typed, outcome_t w);
    script.push_back(row_t'{ev: e, typed: typed, want: w});
  endtask

  task automatic send(event_t e, logic typed = 1'b0, outcome_t w = '0);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    {cmd, channel, note, velocity, block_samples, finished_voice} = e;
    row_typed = typed;
    row_want = w;
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0 || busy) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      limit_m <= pva_pkg::LIM_MAX;
      legato_m <= 1'b0;
      held_m <= '0;
      for (int i = 0; i < NV; i++) begin
        on_m[i] <= 1'b0;
        pitch_m[i] <= '0;
        vel_m[i] <= '0;
        age_m[i] <= '0;
      end
      for (int i = 0; i < 128; i++) depth_m[i] <= '0;
    end else begin
      if (done) begin
        seen = {kind, voice_index, voice_note, voice_velocity, was_active, release_mask,
                held_keys};
        checks_done++;
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 20)
            $display("%0t: unexpected beat, expected none, got %s", $time, show(seen));
        end else begin
          wanted = pending_outcomes.pop_front();
          if (seen !== wanted) begin
            mismatches++;
            if (mismatches <= 20)
              $display("%0t: mismatch, expected %s, got %s", $time, show(wanted),
                       show(seen));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          pva_pkg::REG_POLY_LIMIT: limit_m = cfg_data[4:0];
          pva_pkg::REG_LEGATO: legato_m = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        modeled = allocate_voice({cmd, channel, note, velocity, block_samples,
                                  finished_voice});
        events_total++;
        if (modeled.kind == pva_pkg::KIND_IGNORED) ignored_total++;
        if (modeled.kind == pva_pkg::KIND_START && modeled.was_active) steals++;
        if (modeled.kind == pva_pkg::KIND_LEGATO) retargets++;
        if (modeled.kind == pva_pkg::KIND_RELEASE && modeled.release_mask != 0) releases++;
        pending_outcomes.push_back(row_typed ? row_want : modeled);
      end
    end
  end

  initial begin
    event_t e;
    int     n;
    rst = 1'b1;
    start = 1'b0;
    {cmd, channel, note, velocity, block_samples, finished_voice} = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_want = '0;
    idle_pct = 30;
    mismatches = 0;
    events_total = 0;
    ignored_total = 0;
    checks_done = 0;
    steals = 0;
    retargets = 0;
    releases = 0;
    cfg_writes = 0;

    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_BASE, 7'd0, 7'd127, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_START, 4'd0, 7'd0, 7'd127, 1'b0, 16'h0000, 8'd1));
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_OMNI, 7'd127, 7'd1, 16'hFFFF, 4'hF),
            1'b1, out_of(pva_pkg::KIND_START, 4'd1, 7'd127, 7'd1, 1'b0, 16'h0000, 8'd2));
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, CHAN_STRAY_A, 7'd5, 7'd9, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_IGNORED, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd2));
    add_row(ev_of(pva_pkg::CMD_NOTE_OFF, CHAN_STRAY_B, 7'd0, 7'd127, 16'hFFFF, 4'hF),
            1'b1, out_of(pva_pkg::KIND_IGNORED, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd2));
    add_row(ev_of(CMD_SPARE_LO, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_IGNORED, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd2));
    add_row(ev_of(CMD_SPARE_HI, CHAN_STRAY_B, 7'd127, 7'd127, 16'hFFFF, 4'hF),
            1'b1, out_of(pva_pkg::KIND_IGNORED, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd2));
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_ALT, 7'd0, 7'd64, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_START, 4'd0, 7'd0, 7'd64, 1'b1, 16'h0000, 8'd2));
    add_row(ev_of(pva_pkg::CMD_BLOCK, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'hFFFF, 4'h0),
            1'b1, out_of(pva_pkg::KIND_DONE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd2));
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_RELEASE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0001, 8'd2));
    add_row(ev_of(pva_pkg::CMD_NOTE_OFF, pva_pkg::CHAN_ALT, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_RELEASE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0001, 8'd1));
    add_row(ev_of(pva_pkg::CMD_NOTE_OFF, pva_pkg::CHAN_OMNI, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_RELEASE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0001, 8'd1));
    add_row(ev_of(pva_pkg::CMD_NOTE_OFF, pva_pkg::CHAN_BASE, 7'd127, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_RELEASE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0002, 8'd0));
    add_row(ev_of(pva_pkg::CMD_FINISHED, CHAN_STRAY_B, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_DONE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd0));
    add_row(ev_of(pva_pkg::CMD_FINISHED, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'hF),
            1'b1, out_of(pva_pkg::KIND_DONE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd0));
    add_row(ev_of(pva_pkg::CMD_ALL_OFF, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_DONE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd0));
    add_row(ev_of(pva_pkg::CMD_BLOCK, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b1, out_of(pva_pkg::KIND_DONE, 4'd0, 7'd0, 7'd0, 1'b0, 16'h0000, 8'd0));
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_BASE, 7'd60, 7'd100, 16'h0000, 4'h0),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_ALT, 7'd62, 7'd80, 16'h0000, 4'h0),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_BLOCK, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'd1000, 4'h0),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_OMNI, 7'd64, 7'd127, 16'h0000, 4'h0),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_BASE, 7'd60, 7'd1, 16'h0000, 4'h0),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_NOTE_OFF, pva_pkg::CHAN_ALT, 7'd62, 7'd0, 16'h0000, 4'h0),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_FINISHED, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'h1),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_BASE, 7'd65, 7'd50, 16'h0000, 4'h0),
            1'b0, '0);
    add_row(ev_of(pva_pkg::CMD_ALL_OFF, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'h0),
            1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) send(script[i].ev, script[i].typed, script[i].want);
    drain();
    write_reg(REG_SPARE, 8'($urandom));

    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(pva_pkg::REG_POLY_LIMIT, {3'($urandom), 5'(phase_lim[p])});
      write_reg(pva_pkg::REG_LEGATO, {7'($urandom), phase_leg[p]});
      idle_pct = phase_idle[p];
      n = 0;
      while (n < RAND_PER_PHASE) begin
        e = random_event();
        send(e);
        if (!is_noise(e)) n++;
      end
    end

    // saturate one key depth, then unwind it
    drain();
    write_reg(pva_pkg::REG_POLY_LIMIT, 8'(pva_pkg::LIM_MAX));
    write_reg(pva_pkg::REG_LEGATO, 8'h00);
    idle_pct = 0;
    for (int k = 0; k < 258; k++)
      send(ev_of(pva_pkg::CMD_NOTE_ON, pick_channel(), 7'd42, 7'($urandom_range(1, 127)),
                 16'($urandom), 4'($urandom)));
    for (int k = 0; k < 258; k++)
      send(ev_of($urandom_range(1) ? pva_pkg::CMD_NOTE_OFF : pva_pkg::CMD_NOTE_ON,
                 pick_channel(), 7'd42, 7'd0, 16'($urandom), 4'($urandom)));

    // fill the bank, age every voice alike, then steal
    send(ev_of(pva_pkg::CMD_ALL_OFF, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'h0000, 4'h0));
    for (int v = 0; v < NV; v++)
      send(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_BASE, 7'(100 + v),
                 7'($urandom_range(1, 127)), 16'h0000, 4'h0));
    for (int k = 0; k < 8; k++)
      send(ev_of(pva_pkg::CMD_BLOCK, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'hFFFF, 4'h0));
    send(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_BASE, 7'd20, 7'd90, 16'h0000, 4'h0));
    send(ev_of(pva_pkg::CMD_BLOCK, pva_pkg::CHAN_BASE, 7'd0, 7'd0, 16'd1, 4'h0));
    send(ev_of(pva_pkg::CMD_NOTE_ON, pva_pkg::CHAN_ALT, 7'd21, 7'd91, 16'h0000, 4'h0));
    send(ev_of(pva_pkg::CMD_NOTE_OFF, pva_pkg::CHAN_OMNI, 7'd20, 7'd0, 16'h0000, 4'h0));
    drain();

    $display("covered %0d events (%0d ignored), %0d results checked, %0d config beats",
             events_total, ignored_total, checks_done, cfg_writes);
    $display("voice steals %0d, legato retargets %0d, releases with voices %0d",
             steals, retargets, releases);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
